FILE: design/tce_pkg.sv
// Shared types and constants for the text console cursor engine.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package tce_pkg;

  // Screen geometry.
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int ADDR_W   = $clog2(CELLS);

  // Field widths of the request and result beats.
  localparam int REQ_W  = 2;
  localparam int CHAR_W = 8;
  localparam int NIB_W  = 4;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int LOC_W  = 11;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_MAX = 8'h7F;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  // Rotating colour sequence constants.
  localparam logic [NIB_W-1:0] ROT_STEP = 4'd3;
  localparam logic [NIB_W-1:0] ROT_MOD  = 4'd10;

  typedef enum logic {
    ALU_ADD,
    ALU_LOC
  } alu_op_e;

  typedef struct packed {
    alu_op_e           op;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

endpackage

`default_nettype wire

FILE: design/tce_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on tce_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tce_in_if;
  import tce_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_code;
  logic [NIB_W-1:0]  bg_color;
  logic [NIB_W-1:0]  fg_color;
  logic              color_mode;
  logic [IDX_W-1:0]  cell_index;

  modport source(output valid, req_type, char_code, bg_color, fg_color, color_mode,
                 cell_index, input ready);
  modport sink(input valid, req_type, char_code, bg_color, fg_color, color_mode,
               cell_index, output ready);
endinterface

interface tce_out_if;
  import tce_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [LOC_W-1:0]  cursor_location;

  modport source(output valid, cell_value, cursor_col, cursor_row, cursor_location,
                 input ready);
  modport sink(input valid, cell_value, cursor_col, cursor_row, cursor_location,
               output ready);
endinterface

`default_nettype wire

FILE: design/tce_ram.sv
// Screen store: one write port and one registered read port.
// Depends on tce_pkg for depth, widths and port structs.
`timescale 1ns / 1ps
`default_nettype none

module tce_ram (
  input  wire                          clk_i,
  input  wire tce_pkg::ram_wr_t        wr_i,
  input  wire tce_pkg::ram_rd_t        rd_i,
  output logic [tce_pkg::CELL_W-1:0]   rdata_o
);
  import tce_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_o <= mem[rd_i.addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/tce_alu.sv
// Shared address unit: plain add, or row times COLUMNS plus column.
// Depends on tce_pkg for the request struct and geometry.
`timescale 1ns / 1ps
`default_nettype none

module tce_alu (
  input  wire tce_pkg::alu_req_t       req_i,
  output logic [tce_pkg::ADDR_W-1:0]   y_o
);
  import tce_pkg::*;

  always_comb begin
    unique case (req_i.op)
      ALU_ADD: y_o = req_i.a + req_i.b;
      ALU_LOC: y_o = ADDR_W'(int'(req_i.a) * COLUMNS + int'(req_i.b));
      default: y_o = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/text_console_cursor_engine.sv
// Text console cursor engine. A put steps through the position, execute and finish
// states; a read steps through the read issue, read capture and finish states. The
// result beat is registered in the finish state, which waits while an earlier beat
// is stalled. A put that scrolls copies each row one row up and blanks the bottom row;
// a clear blanks every cell. Reset clears the cursor, the rotating colour and the
// handshake state; the screen store holds no defined value until a clear.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_engine (
  input  wire        clk_i,
  input  wire        rst_ni,
  tce_in_if.sink     in_i,
  tce_out_if.source  out_o
);
  import tce_pkg::*;

  // The sequencer walks each request through a few short steps. Scroll and clear
  // reuse one pointer to sweep the store; the scroll copy also uses the shared unit.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT_POS,
    ST_PUT_EXEC,
    ST_RD_ISSUE,
    ST_RD_CAPT,
    ST_COPY,
    ST_BLANK,
    ST_FINISH
  } state_e;

  state_e            state_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [NIB_W-1:0]  rot_q;

  // Latched request payload.
  logic [CHAR_W-1:0] char_q;
  logic [NIB_W-1:0]  back_q;
  logic [NIB_W-1:0]  fore_q;
  logic              mode_q;
  logic [IDX_W-1:0]  idx_q;

  logic [ADDR_W-1:0] pos_q;
  logic [ADDR_W-1:0] ptr_q;
  logic [ADDR_W-1:0] wptr_q;
  logic              pend_q;
  logic              rd_ok_q;
  logic [CELL_W-1:0] cell_q;

  // Output register.
  logic              out_valid_q;
  logic [CELL_W-1:0] out_cell_q;
  logic [COL_W-1:0]  out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [LOC_W-1:0]  out_loc_q;

  alu_req_t          alu_req;
  logic [ADDR_W-1:0] alu_y;
  ram_wr_t           ram_wr;
  ram_rd_t           ram_rd;
  logic [CELL_W-1:0] ram_rdata;

  logic              in_fire;
  logic              out_free;
  logic              printable;
  logic [NIB_W-1:0]  rot_sum;
  logic [NIB_W-1:0]  rot_next;
  logic [CELL_W-1:0] put_cell;
  logic [COL_W:0]    col_step;
  logic [ROW_W:0]    row_step;
  logic [COL_W:0]    col_wrap;
  logic [ROW_W:0]    row_wrap;

  tce_alu u_alu (
    .req_i (alu_req),
    .y_o   (alu_y)
  );

  tce_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (ram_wr),
    .rd_i    (ram_rd),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid           = out_valid_q;
  assign out_o.cell_value      = out_cell_q;
  assign out_o.cursor_col      = out_col_q;
  assign out_o.cursor_row      = out_row_q;
  assign out_o.cursor_location = out_loc_q;

  // Rotating colour: add three, wrap at ten, and skip zero.
  always_comb begin
    rot_sum = rot_q + ROT_STEP;
    if (rot_sum >= ROT_MOD) begin
      rot_sum = rot_sum - ROT_MOD;
    end
    rot_next = (rot_sum == '0) ? ROT_STEP : rot_sum;
  end

  // Cell written by a printable put. The colour was already stepped in the
  // position cycle, so rot_q holds the current rotating colour here.
  assign printable = (char_q >= CH_SPACE) && (char_q <= CH_PRINT_MAX);
  always_comb begin
    if (mode_q && char_q == CH_SPACE) begin
      put_cell = BLANK_CELL;
    end else if (mode_q) begin
      put_cell = {{NIB_W{1'b0}}, rot_q, char_q};
    end else begin
      put_cell = {back_q, fore_q, char_q};
    end
  end

  // Cursor motion of a put, one bit wider than the fields so that a step past the
  // right edge or the last row can be seen before wrapping.
  always_comb begin
    col_step = {1'b0, col_q};
    row_step = {1'b0, row_q};
    priority if (char_q == CH_BS) begin
      if (col_q != '0) begin
        col_step = col_step - 1'b1;
      end
    end else if (char_q == CH_TAB) begin
      col_step = (COL_W + 1)'((int'(col_q) / TAB_STOP + 1) * TAB_STOP);
    end else if (char_q == CH_CR) begin
      col_step = '0;
    end else if (char_q == CH_LF) begin
      col_step = '0;
      row_step = row_step + 1'b1;
    end else if (printable) begin
      col_step = col_step + 1'b1;
    end else begin
      col_step = {1'b0, col_q};
    end

    col_wrap = col_step;
    row_wrap = row_step;
    if (int'(col_step) >= COLUMNS) begin
      col_wrap = '0;
      row_wrap = row_step + 1'b1;
    end
  end

  // Shared unit and store port requests for each step.
  always_comb begin
    alu_req = '{op: ALU_LOC, a: ADDR_W'(row_q), b: ADDR_W'(col_q)};
    ram_wr  = '{en: 1'b0, addr: pos_q, data: put_cell};
    ram_rd  = '{en: 1'b0, addr: ADDR_W'(idx_q)};
    unique case (state_q)
      ST_PUT_EXEC: begin
        ram_wr.en = printable;
      end
      ST_RD_ISSUE: begin
        ram_rd.en = (int'(idx_q) < CELLS);
      end
      ST_COPY: begin
        // Read the cell one row below while the previous read lands one row up.
        alu_req   = '{op: ALU_ADD, a: ptr_q, b: ADDR_W'(COLUMNS)};
        ram_rd.en = (int'(ptr_q) < CELLS - COLUMNS);
        ram_rd.addr = alu_y;
        ram_wr    = '{en: pend_q, addr: wptr_q, data: ram_rdata};
      end
      ST_BLANK: begin
        ram_wr = '{en: 1'b1, addr: ptr_q, data: BLANK_CELL};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      rot_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // The finish step loads the next beat itself when the current one leaves.
      if (out_valid_q && out_o.ready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            char_q <= in_i.char_code;
            back_q <= in_i.bg_color;
            fore_q <= in_i.fg_color;
            mode_q <= in_i.color_mode;
            idx_q  <= in_i.cell_index;
            cell_q <= '0;
            ptr_q  <= '0;
            pend_q <= 1'b0;
            priority if (in_i.req_type == REQ_PUT) begin
              state_q <= ST_PUT_POS;
            end else if (in_i.req_type == REQ_READ) begin
              state_q <= ST_RD_ISSUE;
            end else if (in_i.req_type == REQ_CLEAR) begin
              col_q   <= '0;
              row_q   <= '0;
              state_q <= ST_BLANK;
            end else begin
              // Unused request code: report the cursor and change nothing.
              state_q <= ST_FINISH;
            end
          end
        end

        ST_PUT_POS: begin
          pos_q <= alu_y;
          if (mode_q) begin
            rot_q <= rot_next;
          end
          state_q <= ST_PUT_EXEC;
        end

        ST_PUT_EXEC: begin
          col_q <= COL_W'(col_wrap);
          if (int'(row_wrap) >= ROWS) begin
            row_q   <= ROW_W'(ROWS - 1);
            state_q <= ST_COPY;
          end else begin
            row_q   <= ROW_W'(row_wrap);
            state_q <= ST_FINISH;
          end
        end

        ST_RD_ISSUE: begin
          rd_ok_q <= (int'(idx_q) < CELLS);
          state_q <= ST_RD_CAPT;
        end

        ST_RD_CAPT: begin
          cell_q  <= rd_ok_q ? ram_rdata : '0;
          state_q <= ST_FINISH;
        end

        ST_COPY: begin
          if (int'(ptr_q) == CELLS - COLUMNS) begin
            // The last pending copy is written this cycle; blank the bottom row next.
            pend_q  <= 1'b0;
            state_q <= ST_BLANK;
          end else begin
            pend_q <= 1'b1;
            wptr_q <= ptr_q;
            ptr_q  <= ptr_q + 1'b1;
          end
        end

        ST_BLANK: begin
          if (int'(ptr_q) == CELLS - 1) begin
            state_q <= ST_FINISH;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end

        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_cell_q  <= cell_q;
            out_col_q   <= col_q;
            out_row_q   <= row_q;
            out_loc_q   <= LOC_W'(alu_y);
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/tce_checker.sv
// Port-level checks on the text console cursor engine, attached by bind.
// Depends on tce_pkg for the screen geometry.
`timescale 1ns / 1ps
`default_nettype none

module tce_checker (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         in_valid_i,
  input wire                         in_ready_i,
  input wire                         out_valid_i,
  input wire                         out_ready_i,
  input wire [tce_pkg::CELL_W-1:0]   cell_value_i,
  input wire [tce_pkg::COL_W-1:0]    cursor_col_i,
  input wire [tce_pkg::ROW_W-1:0]    cursor_row_i,
  input wire [tce_pkg::LOC_W-1:0]    cursor_location_i
);
  import tce_pkg::*;

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cell_value_i))
    else $error("result beat dropped or changed while stalled");

  // The engine works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while the previous one is still in work");

  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (int'(cursor_col_i) < COLUMNS) && (int'(cursor_row_i) < ROWS))
    else $error("cursor reported off screen");

  a_location: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      int'(cursor_location_i) == int'(cursor_row_i) * COLUMNS + int'(cursor_col_i))
    else $error("cursor location does not match column and row");

endmodule

bind text_console_cursor_engine tce_checker u_tce_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .cell_value_i      (out_o.cell_value),
  .cursor_col_i      (out_o.cursor_col),
  .cursor_row_i      (out_o.cursor_row),
  .cursor_location_i (out_o.cursor_location)
);

`default_nettype wire
